@@ rtl/i2cdw_pkg.sv @@
package i2cdw_pkg;

    localparam logic [7:0] ADDR_RESET   = 8'h78;
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    // Slots per byte: 8 bits of two phases each, then the two ack phases
    localparam int unsigned SLOTS_PER_BYTE = 18;
    localparam int unsigned DATA_SLOTS     = 16;
    localparam int unsigned BYTES_PER_REQ  = 3;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] payload;
    } t_req;

    typedef enum logic [2:0] {
        S_START = 3'b001,
        S_BYTE  = 3'b010,
        S_STOP  = 3'b100
    } t_seq_state;

endpackage

@@ rtl/i2cdw_front.sv @@
module i2cdw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               i_kind,
    input  logic [7:0]         i_payload,
    output logic               o_q_valid,
    output i2cdw_pkg::t_req    o_q_req,
    input  logic               i_q_take
);
    import i2cdw_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    logic [7:0]       r_slave_addr;
    t_req             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             accept;
    t_req             new_req;

    assign o_cfg_ready = 1'b1;
    assign full        = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign accept      = push && !full;
    assign o_q_valid   = (r_count != '0);
    assign o_q_req     = r_mem[r_rd_ptr];

    // Classify: pick the control byte and bind the current address to the word
    always_comb begin
        new_req.addr    = r_slave_addr;
        new_req.ctrl    = (i_kind == KIND_DATA) ? CTRL_DATA : CTRL_COMMAND;
        new_req.payload = i_payload;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= ADDR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slave_addr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_wr_ptr] <= new_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({accept, i_q_take})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_take_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_take |-> o_q_valid)
        else $error("queue taken while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");
    a_accept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_q_take) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on accept");
`endif

endmodule

@@ rtl/i2cdw_back.sv @@
module i2cdw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  i2cdw_pkg::t_req    i_q_req,
    output logic               o_q_take,
    output logic               empty,
    input  logic               pop,
    output logic               o_scl_level,
    output logic               o_sda_level,
    output logic               o_last_phase
);
    import i2cdw_pkg::*;

    t_seq_state  r_state, n_state;
    logic        r_active, n_active;
    logic        r_half, n_half;
    logic [4:0]  r_slot, n_slot;
    logic [1:0]  r_bsel, n_bsel;
    logic [23:0] r_shift, n_shift;

    logic        r_ovalid, n_ovalid;
    logic        r_oscl, n_oscl;
    logic        r_osda, n_osda;
    logic        r_olast, n_olast;

    logic        adv;
    logic        at_end;
    logic        take;
    logic        emit;

    assign adv    = !r_ovalid || pop;
    assign at_end = (r_state == S_STOP) && r_half;
    assign emit   = r_active && adv;
    assign take   = adv && i_q_valid && (!r_active || at_end);

    assign o_q_take     = take;
    assign empty        = !r_ovalid;
    assign o_scl_level  = r_oscl;
    assign o_sda_level  = r_osda;
    assign o_last_phase = r_olast;

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_half   = r_half;
        n_slot   = r_slot;
        n_bsel   = r_bsel;
        n_shift  = r_shift;
        n_ovalid = r_ovalid && !pop;
        n_oscl   = r_oscl;
        n_osda   = r_osda;
        n_olast  = r_olast;

        if (emit) begin
            n_ovalid = 1'b1;
            n_olast  = 1'b0;
            case (r_state)
                S_START: begin
                    // SDA falls while SCL is high
                    n_oscl = 1'b1;
                    n_osda = !r_half;
                    if (r_half) begin
                        n_state = S_BYTE;
                        n_slot  = '0;
                        n_bsel  = '0;
                    end
                    n_half = !r_half;
                end
                S_BYTE: begin
                    n_oscl = r_slot[0];
                    if (r_slot < 5'(DATA_SLOTS)) begin
                        n_osda = r_shift[23];
                        // advance to the next bit after its high phase
                        if (r_slot[0]) begin
                            n_shift = {r_shift[22:0], 1'b0};
                        end
                    end else begin
                        // ack slot: release SDA and ignore the response
                        n_osda = 1'b1;
                    end
                    if (r_slot == 5'(SLOTS_PER_BYTE - 1)) begin
                        n_slot = '0;
                        if (r_bsel == 2'(BYTES_PER_REQ - 1)) begin
                            n_state = S_STOP;
                            n_half  = 1'b0;
                        end else begin
                            n_bsel = r_bsel + 1'b1;
                        end
                    end else begin
                        n_slot = r_slot + 1'b1;
                    end
                end
                S_STOP: begin
                    // SDA rises while SCL is high
                    n_oscl  = 1'b1;
                    n_osda  = r_half;
                    n_olast = r_half;
                    if (r_half) begin
                        n_active = 1'b0;
                    end
                    n_half = !r_half;
                end
                default: begin
                    n_state  = S_START;
                    n_active = 1'b0;
                end
            endcase
        end

        if (take) begin
            n_active = 1'b1;
            n_state  = S_START;
            n_half   = 1'b0;
            n_slot   = '0;
            n_bsel   = '0;
            n_shift  = {i_q_req.addr, i_q_req.ctrl, i_q_req.payload};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_START;
            r_active <= 1'b0;
            r_half   <= 1'b0;
            r_slot   <= '0;
            r_bsel   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_half   <= n_half;
            r_slot   <= n_slot;
            r_bsel   <= n_bsel;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_oscl  <= n_oscl;
        r_osda  <= n_osda;
        r_olast <= n_olast;
    end

`ifndef ASSERT_OFF
    a_last_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> (r_oscl && r_osda))
        else $error("last phase word is not a stop release");
    a_byte_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_state == S_BYTE) |->
            (r_slot <= 5'(SLOTS_PER_BYTE - 1) && r_bsel <= 2'(BYTES_PER_REQ - 1)))
        else $error("byte sequencer out of range");
    a_take_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_active && r_state == S_START && !r_half))
        else $error("request load did not restart the sequence");
    a_no_early_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !at_end) |-> !take)
        else $error("request taken in the middle of a sequence");
`endif

endmodule

@@ rtl/i2c_display_write_sequencer_core.sv @@
// A push is queued, loaded into the sequencer, then its first phase word is registered.
// Throughput: 58 phase words per request, one per cycle unless pop stalls the result port;
// the back end's phase sequencer sets this and starts the next request right after a stop.
// A two-entry request queue lets pushes continue while the sequencer or result port stalls.
// Reset (i_rst_n low, synchronous): queue, sequencer and result register are emptied,
// and the slave address byte returns to 0x78.
module i2c_display_write_sequencer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic       i_kind,
    input  logic [7:0] i_payload,
    output logic       empty,
    input  logic       pop,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_last_phase
);
    import i2cdw_pkg::*;

    logic q_valid;
    logic q_take;
    t_req q_req;

    i2cdw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_kind      (i_kind),
        .i_payload   (i_payload),
        .o_q_valid   (q_valid),
        .o_q_req     (q_req),
        .i_q_take    (q_take)
    );

    i2cdw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_req      (q_req),
        .o_q_take     (q_take),
        .empty        (empty),
        .pop          (pop),
        .o_scl_level  (o_scl_level),
        .o_sda_level  (o_sda_level),
        .o_last_phase (o_last_phase)
    );

endmodule

@@ tb/i2c_display_write_sequencer_core_tb.sv @@
`timescale 1ns / 1ps

module i2c_display_write_sequencer_core_tb;
    import i2cdw_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned RANDOM_PER_SETTING = 39;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct {
        logic       kind;
        logic [7:0] payload;
    } t_write_req;

    typedef struct {
        logic scl;
        logic sda;
        logic last;
    } t_bus_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = 8'h00;
    logic       push = 1'b0;
    logic       full;
    logic       i_kind = 1'b0;
    logic [7:0] i_payload = 8'h00;
    logic       empty;
    logic       pop = 1'b0;
    logic       o_scl_level;
    logic       o_sda_level;
    logic       o_last_phase;

    t_write_req requests_waiting[$];
    t_bus_phase phases_due[$];

    logic [7:0]  addr_shadow = ADDR_RESET;
    int unsigned mismatches = 0;
    int unsigned writes_sent = 0;
    int unsigned data_writes = 0;
    int unsigned phases_seen = 0;
    int unsigned addr_writes = 0;
    int unsigned push_gap = 0;
    int unsigned pop_stall = 0;
    int unsigned idle_cycles = 0;
    bit          steady_push = 1'b0;
    bit          steady_pop = 1'b0;
    t_bus_phase  phase_exp;
    t_write_req  next_req;

    i2c_display_write_sequencer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_kind      (i_kind),
        .i_payload   (i_payload),
        .empty       (empty),
        .pop         (pop),
        .o_scl_level (o_scl_level),
        .o_sda_level (o_sda_level),
        .o_last_phase(o_last_phase)
    );

    always #1 i_clk = ~i_clk;

    function automatic void add_phase(logic scl, logic sda, logic last);
        t_bus_phase p;
        p.scl  = scl;
        p.sda  = sda;
        p.last = last;
        phases_due.push_back(p);
    endfunction

    // Start, address, control, payload (MSB first, ack released), stop
    function automatic void queue_write_phases(logic kind, logic [7:0] payload);
        logic [7:0] bytes [3];
        bytes[0] = addr_shadow;
        bytes[1] = (kind == KIND_DATA) ? CTRL_DATA : CTRL_COMMAND;
        bytes[2] = payload;
        add_phase(1'b1, 1'b1, 1'b0);
        add_phase(1'b1, 1'b0, 1'b0);
        for (int b = 0; b < 3; b++) begin
            for (int i = 7; i >= 0; i--) begin
                add_phase(1'b0, bytes[b][i], 1'b0);
                add_phase(1'b1, bytes[b][i], 1'b0);
            end
            add_phase(1'b0, 1'b1, 1'b0);
            add_phase(1'b1, 1'b1, 1'b0);
        end
        add_phase(1'b1, 1'b0, 1'b0);
        add_phase(1'b1, 1'b1, 1'b1);
    endfunction

    function automatic int unsigned pick_gap(bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void add_request(logic kind, logic [7:0] payload);
        t_write_req req;
        req.kind    = kind;
        req.payload = payload;
        requests_waiting.push_back(req);
    endfunction

    function automatic void add_random_request();
        logic [7:0] payload;
        if ($urandom_range(0, 99) < 15) begin
            payload = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
            payload = 8'($urandom_range(0, 255));
        end
        add_request($urandom_range(0, 1) ? KIND_DATA : KIND_COMMAND, payload);
    endfunction

    function automatic void check_field(string name, logic expected, logic actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch on phase word %0d: expected %b, actual %b",
                     $time, name, phases_seen, expected, actual);
            mismatches++;
        end
    endfunction

    task automatic write_address(logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        addr_shadow = value;
        addr_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (requests_waiting.size() != 0 || push || phases_due.size() != 0);
        // hold off so the sequencer is surely idle before touching the register
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            push_gap = 0;
        end else begin
            if (push && !full) begin
                queue_write_phases(i_kind, i_payload);
                writes_sent++;
                if (i_kind == KIND_DATA) data_writes++;
                if ($urandom_range(0, 49) == 0) steady_push = !steady_push;
                push_gap = pick_gap(steady_push);
            end
            if (push && full) begin
                // hold the word until the queue takes it
            end else if (push_gap > 0) begin
                push_gap--;
                push <= 1'b0;
            end else if (requests_waiting.size() > 0) begin
                next_req = requests_waiting.pop_front();
                push      <= 1'b1;
                i_kind    <= next_req.kind;
                i_payload <= next_req.payload;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Phase word monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_stall = 0;
        end else begin
            if (pop && !empty) begin
                if (phases_due.size() == 0) begin
                    $display("%0t: unexpected phase word scl=%b sda=%b last=%b",
                             $time, o_scl_level, o_sda_level, o_last_phase);
                    mismatches++;
                end else begin
                    phase_exp = phases_due.pop_front();
                    check_field("scl_level", phase_exp.scl, o_scl_level);
                    check_field("sda_level", phase_exp.sda, o_sda_level);
                    check_field("last_phase", phase_exp.last, o_last_phase);
                end
                phases_seen++;
                if ($urandom_range(0, 199) == 0) steady_pop = !steady_pop;
                pop_stall = pick_gap(steady_pop);
            end
            if (pop_stall > 0) begin
                pop_stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: any handshake clears the count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d phase words pending",
                         $time, STALL_LIMIT, phases_due.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] addr_value;
        logic [7:0] edge_bytes [6];
        edge_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset address, both kinds with edge payloads
        for (int i = 0; i < 6; i++) begin
            add_request(KIND_COMMAND, edge_bytes[i]);
            add_request(KIND_DATA, edge_bytes[i]);
        end
        wait_drained();

        for (int s = 0; s < 4; s++) begin
            case (s)
                0: addr_value = 8'h00;
                1: addr_value = 8'hFF;
                2: addr_value = 8'($urandom_range(0, 255));
                default: addr_value = ADDR_RESET;
            endcase
            write_address(addr_value);
            @(negedge i_clk);
            for (int n = 0; n < RANDOM_PER_SETTING; n++) add_random_request();
            wait_drained();
        end

        $display("Sent %0d write requests (%0d data, %0d command) over %0d address settings,",
                 writes_sent, data_writes, writes_sent - data_writes, addr_writes + 1);
        $display("checked %0d bus phase words.", phases_seen);
        if (mismatches == 0 && phases_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
